// ----- hdl/ssfr_pkg.sv -----
`timescale 1ns / 1ps

package ssfr_pkg;

  localparam int unsigned LEN_W           = 13;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned OUT_TDATA_W     = 16;
  localparam int unsigned MAX_PAYLOAD_DEF = 4096;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 13'd64;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] STOP_BYTE  = 8'hFF;
  localparam logic [23:0]       START_WIN  = 24'h555555;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic              payload_last;
    logic              stop_ok;
  } res_t;

endpackage

// ----- hdl/ssfr_in_stage.sv -----
`timescale 1ns / 1ps

module ssfr_in_stage
  import ssfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              adv,
  output logic              s1_valid,
  output logic [BYTE_W-1:0] s1_byte
);

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              accept;

  assign in_tready = !valid_r || adv;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// ----- hdl/ssfr_core.sv -----
`timescale 1ns / 1ps

module ssfr_core
  import ssfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [LEN_W-1:0]  cfg_data,
  input  logic              adv,
  input  logic [BYTE_W-1:0] s1_byte,
  output logic              has_res,
  output res_t              res
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_STOP    = 2'd2;

  logic [LEN_W-1:0] len_r;
  logic [1:0]       phase_r, phase_nxt;
  logic [23:0]      win_r, win_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       stop_cnt_r, stop_cnt_nxt;
  logic             mism_r, mism_nxt;

  logic [LEN_W-1:0] eff_len;
  logic             last;

  always_comb begin
    eff_len = len_r;
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if ({4'b0, len_r} > 17'(MAX_PAYLOAD)) begin
      eff_len = LEN_W'(MAX_PAYLOAD);
    end
  end

  assign last = ({1'b0, cnt_r} + (LEN_W+1)'(1)) >= {1'b0, eff_len};

  always_comb begin
    phase_nxt    = phase_r;
    win_nxt      = win_r;
    cnt_nxt      = cnt_r;
    stop_cnt_nxt = stop_cnt_r;
    mism_nxt     = mism_r;
    has_res      = 1'b0;
    res          = '0;
    unique case (phase_r)
      PH_PAYLOAD: begin
        has_res           = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.data_byte     = s1_byte;
        res.payload_last  = last;
        if (last) begin
          cnt_nxt      = '0;
          phase_nxt    = PH_STOP;
          stop_cnt_nxt = '0;
          mism_nxt     = 1'b0;
        end else begin
          cnt_nxt = cnt_r + LEN_W'(1);
        end
      end
      PH_STOP: begin
        mism_nxt = mism_r || (s1_byte != STOP_BYTE);
        if (stop_cnt_r == 2'd3) begin
          has_res      = 1'b1;
          res.kind     = KIND_STATUS;
          res.stop_ok  = !mism_nxt;
          phase_nxt    = PH_HUNT;
          win_nxt      = '0;
          stop_cnt_nxt = '0;
          mism_nxt     = 1'b0;
        end else begin
          stop_cnt_nxt = stop_cnt_r + 2'd1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (win_r == START_WIN && s1_byte == START_BYTE) begin
          win_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
          cnt_nxt   = '0;
        end else begin
          win_nxt = {win_r[15:0], s1_byte};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= LEN_RESET;
      phase_r    <= PH_HUNT;
      win_r      <= '0;
      cnt_r      <= '0;
      stop_cnt_r <= '0;
      mism_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
      if (adv) begin
        phase_r    <= phase_nxt;
        win_r      <= win_nxt;
        cnt_r      <= cnt_nxt;
        stop_cnt_r <= stop_cnt_nxt;
        mism_r     <= mism_nxt;
      end
    end
  end

endmodule

// ----- hdl/ssfr_out_stage.sv -----
`timescale 1ns / 1ps

module ssfr_out_stage
  import ssfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  res_t                   res,
  output logic                   busy,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign busy       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-BYTE_W-1){1'b0}}, res_r.stop_ok, res_r.data_byte};
  assign out_tlast  = res_r.payload_last;
  assign out_tuser  = res_r.kind;

endmodule

// ----- hdl/start_stop_frame_receiver.sv -----
`timescale 1ns / 1ps
// Start/stop framed byte receiver.
// in_*  : one received byte per word. The block hunts for 55 55 55 55, then
//         passes exactly payload_length bytes, then checks four stop bytes
//         against FF FF FF FF.
// out_* : one word per payload byte (tuser 0, tlast on the final byte) and
//         one status word per frame after the fourth stop byte (tuser 1,
//         tdata bit 8 set when all stop bytes matched). Hunting and stop
//         bytes other than the fourth give no word.
// cfg_* : payload_length write, taken at once; 0 acts as 1, values above
//         MAX_PAYLOAD act as MAX_PAYLOAD. Write only while idle.
// Path: an accepted word goes through the input register, the decode and
//         the output register, in that order.
// Throughput: one word per cycle; the single output register parts the two
//         sides, and in_tready falls only when the output register is full,
//         not taken, and the waiting byte makes a result.
// Reset (rst_n low, synchronous): both stages empty, hunting with an empty
//         window, payload_length back to 64.
// Stall: with out_tready low the output word holds; bytes that make no result
//         still flow through.
module start_stop_frame_receiver
  import ssfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [8] stop_ok
  output logic                   out_tlast,
  output logic                   out_tuser,  // [0] kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LEN_W-1:0]       cfg_data
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              adv;
  logic              has_res;
  logic              out_busy;
  res_t              res;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && !(has_res && out_busy);

  ssfr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  ssfr_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .s1_byte   (s1_byte),
    .has_res   (has_res),
    .res       (res)
  );

  ssfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && has_res),
    .res        (res),
    .busy       (out_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- hdl/ssfr_checker.sv -----
`timescale 1ns / 1ps

module ssfr_checker
  import ssfr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATUS |-> out_tdata[7:0] == '0 && !out_tlast)
    else $error("status word carries payload fields");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PAYLOAD |-> !out_tdata[8])
    else $error("payload word carries stop status");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while output free");

endmodule

bind start_stop_frame_receiver ssfr_checker u_ssfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- bench/deframe_checker.sv -----
`timescale 1ns / 1ps

module deframe_checker
  import ssfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [LEN_W-1:0]       cfg_data,
  output int                     pending,
  output int                     fail_count
);

  typedef enum logic [1:0] {SEEK_START, IN_PAYLOAD, IN_STOP} rx_phase_t;

  rx_phase_t         phase;
  logic [23:0]       window;
  logic [15:0]       byte_count;
  logic [1:0]        stop_seen;
  logic              stop_bad;
  logic [LEN_W-1:0]  frame_len;
  res_t              expected_words[$];
  int                errs = 0;

  assign fail_count = errs;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    errs++;
  endtask

  function automatic int unsigned active_len(input logic [LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_PAYLOAD_DEF) return MAX_PAYLOAD_DEF;
    return v;
  endfunction

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    res_t r;
    r = '0;
    case (phase)
      IN_PAYLOAD: begin
        r.kind         = KIND_PAYLOAD;
        r.data_byte    = b;
        r.payload_last = (int'(byte_count) + 1 >= int'(active_len(frame_len)));
        expected_words.push_back(r);
        if (r.payload_last) begin
          byte_count = '0;
          phase      = IN_STOP;
          stop_seen  = '0;
          stop_bad   = 1'b0;
        end else begin
          byte_count = byte_count + 16'd1;
        end
      end
      IN_STOP: begin
        if (b != STOP_BYTE) stop_bad = 1'b1;
        if (stop_seen == 2'd3) begin
          r.kind    = KIND_STATUS;
          r.stop_ok = !stop_bad;
          expected_words.push_back(r);
          phase     = SEEK_START;
          window    = '0;
          stop_seen = '0;
          stop_bad  = 1'b0;
        end else begin
          stop_seen = stop_seen + 2'd1;
        end
      end
      default: begin
        phase = SEEK_START;
        if (window == START_WIN && b == START_BYTE) begin
          window     = '0;
          phase      = IN_PAYLOAD;
          byte_count = '0;
        end else begin
          window = {window[15:0], b};
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      phase      = SEEK_START;
      window     = '0;
      byte_count = '0;
      stop_seen  = '0;
      stop_bad   = 1'b0;
      frame_len  = LEN_RESET;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word tdata=%h tlast=%b tuser=%b",
                                    out_tdata, out_tlast, out_tuser));
        end else begin
          want = expected_words.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind %b, want %b", out_tuser, want.kind));
          if (out_tdata[7:0] !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, want %h", out_tdata[7:0],
                                      want.data_byte));
          if (out_tlast !== want.payload_last)
            report_mismatch($sformatf("payload_last %b, want %b", out_tlast,
                                      want.payload_last));
          if (out_tdata[8] !== want.stop_ok)
            report_mismatch($sformatf("stop_ok %b, want %b", out_tdata[8], want.stop_ok));
        end
      end
      if (cfg_valid && cfg_ready) frame_len = cfg_data;
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
    end
    pending <= expected_words.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ssfr_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic [LEN_W-1:0]       cfg_data   = '0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire [OUT_TDATA_W-1:0]  out_tdata;
  wire                    out_tlast;
  wire                    out_tuser;
  wire                    cfg_ready;
  int                     pending;
  int                     fail_count;

  int                     tx_idle_pct = 0;
  int                     rx_idle_pct = 0;
  int unsigned            cur_len     = LEN_RESET;
  int unsigned            sent_items  = 0;

  start_stop_frame_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  deframe_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(3))
      0: return START_BYTE;
      1: return STOP_BYTE;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return '0;
      1: return LEN_W'($urandom_range(64, 17));
      default: return LEN_W'($urandom_range(16, 1));
    endcase
  endfunction

  // enter and leave on a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_len = (v == '0) ? 1 : ((v > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : v);
  endtask

  task automatic send_frame(input bit bad_stop, input bit cut_short);
    int unsigned extra;
    int unsigned n;
    int unsigned bad_at;
    extra  = ($urandom_range(7) == 0) ? 1 : 0;
    n      = cur_len - extra;
    if (cut_short) n = $urandom_range(n);
    bad_at = $urandom_range(3);
    repeat ($urandom_range(2)) send_byte(noise_byte());
    repeat (4 + extra) send_byte(START_BYTE);
    repeat (n) send_byte(noise_byte());
    if (!cut_short) begin
      for (int k = 0; k < 4; k++)
        send_byte((bad_stop && k == bad_at) ? BYTE_W'($urandom_range(254)) : STOP_BYTE);
    end
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [BYTE_W-1:0] b;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(6, 1)) send_byte(noise_byte());
      end else if (pick < 22) begin
        // broken start: short run of start bytes, then anything else
        repeat ($urandom_range(3, 1)) send_byte(START_BYTE);
        b = BYTE_W'($urandom_range(255));
        if (b == START_BYTE) b = 8'h54;
        send_byte(b);
      end else begin
        send_frame($urandom_range(4) == 0, $urandom_range(19) == 0);
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] seq[$];
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // shrink the length while a frame is open
    seq = '{START_BYTE, START_BYTE, START_BYTE, START_BYTE, 8'hA5, 8'h5A};
    foreach (seq[i]) send_byte(seq[i]);
    settle();
    write_len(13'd2);
    seq = '{8'h3C, STOP_BYTE, STOP_BYTE, STOP_BYTE, 8'h7F};
    foreach (seq[i]) send_byte(seq[i]);
    settle();

    write_len(13'd1);
    seq = '{8'h00, STOP_BYTE, START_BYTE, START_BYTE, START_BYTE, 8'hAA,
            START_BYTE, START_BYTE, START_BYTE, START_BYTE, START_BYTE,
            STOP_BYTE, STOP_BYTE, STOP_BYTE, STOP_BYTE,
            START_BYTE, START_BYTE, START_BYTE, START_BYTE, 8'h00,
            STOP_BYTE, 8'h00, STOP_BYTE, STOP_BYTE};
    foreach (seq[i]) send_byte(seq[i]);
    settle();

    for (int r = 0; r < 3; r++) begin
      tx_idle_pct = (r == 0) ? 33 : ((r == 1) ? 73 : 0);
      rx_idle_pct = (r == 0) ? 73 : ((r == 1) ? 33 : 0);
      repeat (3) begin
        settle();
        write_len(pick_len());
        random_traffic(65);
      end
    end

    // widest register value, then shrink it while the frame is open
    settle();
    write_len(13'h1FFF);
    repeat (4) send_byte(START_BYTE);
    repeat (20) send_byte(noise_byte());
    settle();
    write_len(13'd3);
    random_traffic(30);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- start_stop_frame_receiver.f -----
hdl/ssfr_pkg.sv
hdl/ssfr_in_stage.sv
hdl/ssfr_core.sv
hdl/ssfr_out_stage.sv
hdl/start_stop_frame_receiver.sv
hdl/ssfr_checker.sv
bench/deframe_checker.sv
bench/tb_top.sv
